[hw/rtl/des_rkg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_rkg_pkg
// Types, permutation tables and helper functions of the DES key schedule.
// ----------------------------------------------------------------------------
package des_rkg_pkg;

   localparam int KeyWidth    = 64;
   localparam int HalfWidth   = 28;
   localparam int CdWidth     = 56;
   localparam int SubkeyWidth = 48;
   localparam int RoundWidth  = 4;

   localparam logic [RoundWidth-1:0] LastRound = 4'd15;

   // set bit r when round r rotates by two
   localparam logic [15:0] RotTwoMask = 16'h7EFC;

   localparam logic [7:0] Pc1Table [CdWidth] = '{
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
      8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
      8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
      8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
      8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
   };

   localparam logic [7:0] Pc2Table [SubkeyWidth] = '{
      8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
      8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
      8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
      8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
   };

   typedef struct packed {
      logic [HalfWidth-1:0] c;
      logic [HalfWidth-1:0] d;
   } cd_item_type;

   // key selection permutation, leftmost key bit is the msb
   function automatic cd_item_type pc1_permute(input logic [KeyWidth-1:0] key);
      logic [CdWidth-1:0] cd;
      logic [5:0]         idx;
      cd = '0;
      for (int i = 0; i < CdWidth; i++) begin
         idx = 6'(KeyWidth - int'(Pc1Table[i]));
         cd[CdWidth-1-i] = key[idx];
      end
      return cd_item_type'(cd);
   endfunction

   // compression permutation over the joined halves
   function automatic logic [SubkeyWidth-1:0] pc2_permute(input cd_item_type cd);
      logic [CdWidth-1:0]     joined;
      logic [SubkeyWidth-1:0] sk;
      logic [5:0]             idx;
      joined = cd;
      sk = '0;
      for (int i = 0; i < SubkeyWidth; i++) begin
         idx = 6'(CdWidth - int'(Pc2Table[i]));
         sk[SubkeyWidth-1-i] = joined[idx];
      end
      return sk;
   endfunction

   function automatic logic [HalfWidth-1:0] rotate_half(input logic [HalfWidth-1:0] x,
                                                        input logic two);
      return two ? {x[HalfWidth-3:0], x[HalfWidth-1:HalfWidth-2]}
                 : {x[HalfWidth-2:0], x[HalfWidth-1]};
   endfunction

endpackage

[hw/rtl/des_round_key_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_round_key_generator_top
// The first subkey of a key passes the front register, queue and output register;
// then one subkey per cycle follows while rsp_stall does not hold the output.
// The single round engine issues the 16 subkeys of a key in sequence and takes
// the next key only after the last of them; three further keys may wait.
// Reset clears all control state synchronously; no clearing pass is needed.
// ----------------------------------------------------------------------------
module des_round_key_generator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [des_rkg_pkg::KeyWidth-1:0]     req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [des_rkg_pkg::SubkeyWidth-1:0]  rsp_subkey,
   output logic [des_rkg_pkg::RoundWidth-1:0]   rsp_round_index,
   output logic                                 rsp_last
);
   import des_rkg_pkg::*;

   logic        push_valid;
   logic        push_stall;
   cd_item_type push_data;
   logic        pop_valid;
   logic        pop_ready;
   cd_item_type pop_data;

   des_rkg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_key    (req_key),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data)
   );

   des_rkg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   des_rkg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_subkey      (rsp_subkey),
      .rsp_round_index (rsp_round_index),
      .rsp_last        (rsp_last)
   );

endmodule

[hw/rtl/des_rkg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_rkg_front
// Takes keys, applies the key selection permutation and queues the halves.
// ----------------------------------------------------------------------------
module des_rkg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [des_rkg_pkg::KeyWidth-1:0]  req_key,
   output logic                              push_valid,
   input  logic                              push_stall,
   output des_rkg_pkg::cd_item_type          push_data
);
   import des_rkg_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   cd_item_type cd_ff;
   cd_item_type cd_in;
   logic        accept;

   assign req_stall  = valid_ff && push_stall;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_data  = cd_ff;

   always_comb begin
      valid_in = valid_ff;
      cd_in    = cd_ff;
      if (accept) begin
         valid_in = 1'b1;
         cd_in    = pc1_permute(req_key);
      end else if (valid_ff && !push_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cd_ff <= cd_in;
   end

endmodule

[hw/rtl/des_rkg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_rkg_queue
// Two-entry queue of key halves between front and round engine.
// ----------------------------------------------------------------------------
module des_rkg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_stall,
   input  des_rkg_pkg::cd_item_type  push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output des_rkg_pkg::cd_item_type  pop_data
);
   import des_rkg_pkg::*;

   cd_item_type entry_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        do_push;
   logic        do_pop;

   assign push_stall = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/des_rkg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_rkg_back
// Round engine: rotates the halves once per cycle unless rsp_stall holds the output, and registers each subkey.
// ----------------------------------------------------------------------------
module des_rkg_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  des_rkg_pkg::cd_item_type             pop_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [des_rkg_pkg::SubkeyWidth-1:0]  rsp_subkey,
   output logic [des_rkg_pkg::RoundWidth-1:0]   rsp_round_index,
   output logic                                 rsp_last
);
   import des_rkg_pkg::*;

   logic                   busy_ff;
   logic                   busy_in;
   cd_item_type            cd_ff;
   cd_item_type            cd_in;
   logic [RoundWidth-1:0]  round_ff;
   logic [RoundWidth-1:0]  round_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [SubkeyWidth-1:0] subkey_ff;
   logic [SubkeyWidth-1:0] subkey_in;
   logic [RoundWidth-1:0]  index_ff;
   logic [RoundWidth-1:0]  index_in;
   logic                   last_ff;
   logic                   last_in;

   logic                   advance;
   logic                   work;
   cd_item_type            src;
   cd_item_type            rot;
   logic [RoundWidth-1:0]  rnd;
   logic                   two;

   assign advance = !out_valid_ff || !rsp_stall;
   assign work    = busy_ff || pop_valid;
   // a new key starts only once the previous one has issued its last round
   assign pop_ready = advance && !busy_ff;

   always_comb begin
      src   = busy_ff ? cd_ff : pop_data;
      rnd   = busy_ff ? round_ff : '0;
      two   = RotTwoMask[rnd];
      rot.c = rotate_half(src.c, two);
      rot.d = rotate_half(src.d, two);

      busy_in      = busy_ff;
      cd_in        = cd_ff;
      round_in     = round_ff;
      out_valid_in = out_valid_ff;
      subkey_in    = subkey_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = work;
         if (work) begin
            cd_in     = rot;
            subkey_in = pc2_permute(rot);
            index_in  = rnd;
            last_in   = (rnd == LastRound);
            busy_in   = (rnd != LastRound);
            round_in  = rnd + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
      cd_ff     <= cd_in;
      subkey_ff <= subkey_in;
      index_ff  <= index_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_subkey      = subkey_ff;
   assign rsp_round_index = index_ff;
   assign rsp_last        = last_ff;

endmodule
